// File: rtl/core/button_autorepeat_scanner_assert.svh
// assertion macros shared by the scanner modules
`ifndef BUTTON_AUTOREPEAT_SCANNER_ASSERT_SVH
`define BUTTON_AUTOREPEAT_SCANNER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define BAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// next-cycle implication, off while reset is asserted
`define BAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

// File: rtl/core/bas_pkg.sv
package bas_pkg;

    localparam int FIELD_W    = 12;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE  = 2'd1;

    localparam logic [CFG_W-1:0] DELAY_RESET = 16'd500;
    localparam logic [CFG_W-1:0] RATE_RESET  = 16'd100;

    typedef struct packed {
        logic [FIELD_W-1:0] button_levels;
        logic [TIME_W-1:0]  now_ms;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] pressed_mask;
        logic [FIELD_W-1:0] just_pressed_mask;
        logic [FIELD_W-1:0] just_released_mask;
        logic [FIELD_W-1:0] repeat_mask;
    } t_out_item;

    // repeat timing shared by all lanes
    typedef struct packed {
        logic [CFG_W-1:0] delay_ms;
        logic [CFG_W-1:0] rate_ms;
    } t_repeat_cfg;

    // what the lanes and the level tracker hand to the merge stage
    typedef struct packed {
        logic [FIELD_W-1:0] levels;
        logic [FIELD_W-1:0] prev;
        logic [FIELD_W-1:0] fire;
    } t_poll_flags;

endpackage

// File: rtl/core/bas_lane.sv
module bas_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_level,
    input  logic                         i_prev,
    input  logic [bas_pkg::TIME_W-1:0]   i_now,
    input  bas_pkg::t_repeat_cfg         i_cfg,
    output logic                         o_fire
);

    `include "button_autorepeat_scanner_assert.svh"

    logic [bas_pkg::TIME_W-1:0] r_deadline;
    logic [bas_pkg::TIME_W-1:0] n_deadline;
    logic                       w_due;

    assign w_due  = (i_now >= r_deadline);
    assign o_fire = i_level && (!i_prev || w_due);

    always_comb begin
        n_deadline = r_deadline;
        if (i_accept && i_level) begin
            if (!i_prev) begin
                n_deadline = i_now + bas_pkg::TIME_W'(i_cfg.delay_ms);
            end else if (w_due) begin
                n_deadline = i_now + bas_pkg::TIME_W'(i_cfg.rate_ms);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
        end else begin
            r_deadline <= n_deadline;
        end
    end

    `BAS_ASSERT_SAME(a_new_press_fires, i_clk, i_rst_n, i_level && !i_prev, o_fire)
    `BAS_ASSERT_SAME(a_released_quiet, i_clk, i_rst_n, !i_level, !o_fire)

endmodule

// File: rtl/core/bas_merge.sv
module bas_merge (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bas_pkg::t_poll_flags  i_flags,
    output logic                  o_full,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bas_pkg::t_out_item    o_out
);

    `include "button_autorepeat_scanner_assert.svh"

    bas_pkg::t_out_item w_item;
    bas_pkg::t_out_item r_out;
    bas_pkg::t_out_item n_out;
    bas_pkg::t_out_item r_skid;
    bas_pkg::t_out_item n_skid;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               r_skid_valid;
    logic               n_skid_valid;
    logic               w_pop;

    // combine lane results into the four masks
    always_comb begin
        w_item.pressed_mask       = i_flags.levels;
        w_item.just_pressed_mask  = i_flags.levels & ~i_flags.prev;
        w_item.just_released_mask = i_flags.prev & ~i_flags.levels;
        w_item.repeat_mask        = i_flags.fire;
    end

    assign w_pop = r_out_valid && !i_out_stall;

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || w_pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_item;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = w_item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `BAS_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, i_push, !r_skid_valid)
    `BAS_ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BAS_ASSERT_NEXT(a_empty_stays_shallow, i_clk, i_rst_n, !r_out_valid, !r_skid_valid)

endmodule

// File: rtl/core/button_autorepeat_scanner.sv
// button auto-repeat scanner: each input item is one poll of the button levels
// with the current millisecond time; each poll gives exactly one result item with
// the held, newly pressed, newly released and repeat-firing masks. every button
// has its own lane holding a 32-bit deadline with one compare and one add; a new
// press fires at once and arms now plus repeat_delay_ms, a held button fires when
// now_ms >= deadline (plain unsigned compare) and re-arms at now plus
// repeat_rate_ms. one poll is taken every clock cycle unless o_in_stall is high;
// the result is held in the output register, and a second skid register
// lets a poll be taken while a result waits, so o_in_stall only rises once two
// results are queued. level bits at or above NUM_BUTTONS are ignored. register 0
// is the repeat delay (reset 500), register 1 the repeat rate (reset 100);
// writes to other indexes are dropped. write config only while no poll is in
// flight.
module button_autorepeat_scanner #(
    parameter int NUM_BUTTONS = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bas_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bas_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [bas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bas_pkg::CFG_W-1:0]      i_cfg_data
);

    `include "button_autorepeat_scanner_assert.svh"

    // buttons past the field width can never be pressed, so they get no lane
    localparam int LANES = (NUM_BUTTONS < bas_pkg::FIELD_W) ? NUM_BUTTONS
                                                            : bas_pkg::FIELD_W;
    localparam logic [bas_pkg::FIELD_W-1:0] LEVEL_MASK =
        bas_pkg::FIELD_W'((1 << LANES) - 1);

    bas_pkg::t_repeat_cfg          r_cfg;
    logic [bas_pkg::FIELD_W-1:0]   r_last_levels;
    logic [bas_pkg::FIELD_W-1:0]   w_levels;
    logic [bas_pkg::FIELD_W-1:0]   w_fire;
    logic [LANES-1:0]              w_lane_fire;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_edge_overlap;
    bas_pkg::t_poll_flags          w_flags;

    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;
    assign w_levels   = i_in.button_levels & LEVEL_MASK;

    // config registers, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_ms <= bas_pkg::DELAY_RESET;
            r_cfg.rate_ms  <= bas_pkg::RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bas_pkg::CFG_IDX_DELAY: r_cfg.delay_ms <= i_cfg_data;
                bas_pkg::CFG_IDX_RATE:  r_cfg.rate_ms  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // previous poll's levels for edge detection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_levels <= '0;
        end else if (w_accept) begin
            r_last_levels <= w_levels;
        end
    end

    // one lane per button
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        bas_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_accept(w_accept),
            .i_level (w_levels[g]),
            .i_prev  (r_last_levels[g]),
            .i_now   (i_in.now_ms),
            .i_cfg   (r_cfg),
            .o_fire  (w_lane_fire[g])
        );
    end

    always_comb begin
        w_fire = '0;
        w_fire[LANES-1:0] = w_lane_fire;
    end

    assign w_flags.levels = w_levels;
    assign w_flags.prev   = r_last_levels;
    assign w_flags.fire   = w_fire;

    // merge lane results and hold them for the output side
    bas_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_flags    (w_flags),
        .o_full     (w_full),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    assign w_edge_overlap = |(o_out.just_pressed_mask & o_out.just_released_mask);

    // a button cannot be both newly pressed and newly released
    `BAS_ASSERT_SAME(a_edges_exclusive, i_clk, i_rst_n, o_out_valid, !w_edge_overlap)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int BUTTON_COUNT = 12;
    localparam logic [bas_pkg::FIELD_W-1:0] BUTTON_MASK =
        bas_pkg::FIELD_W'((1 << BUTTON_COUNT) - 1);
    localparam int CYCLE_LIMIT = 400000;
    localparam int POLLS_PER_PHASE = 280;
    localparam int RANDOM_PHASES = 6;
    localparam int LONG_HOLD_CYCLES = 80;

    // unused register slots, writes there must leave the timing alone
    localparam logic [bas_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [bas_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    // tracks the repeat timing per button and holds the masks each poll should produce
    class autorepeat_scoreboard;
        logic [bas_pkg::CFG_W-1:0]   delay_ms;
        logic [bas_pkg::CFG_W-1:0]   rate_ms;
        logic [bas_pkg::FIELD_W-1:0] last_levels;
        logic [bas_pkg::TIME_W-1:0]  deadline [BUTTON_COUNT];
        bas_pkg::t_out_item          expected_masks [$];
        int                          mismatches;
        int                          results_seen;
        int                          firings;

        function new();
            delay_ms     = bas_pkg::DELAY_RESET;
            rate_ms      = bas_pkg::RATE_RESET;
            last_levels  = '0;
            mismatches   = 0;
            results_seen = 0;
            firings      = 0;
            foreach (deadline[b]) deadline[b] = '0;
        endfunction

        function void write_register(logic [bas_pkg::CFG_IDX_W-1:0] idx,
                                     logic [bas_pkg::CFG_W-1:0] data);
            case (idx)
                bas_pkg::CFG_IDX_DELAY: delay_ms = data;
                bas_pkg::CFG_IDX_RATE:  rate_ms  = data;
                default: ;
            endcase
        endfunction

        // accepted poll: work out held, edge and repeat masks
        function void note_poll(bas_pkg::t_in_item poll);
            bas_pkg::t_out_item          masks;
            logic [bas_pkg::FIELD_W-1:0] levels;
            logic [bas_pkg::FIELD_W-1:0] prev;
            logic [bas_pkg::FIELD_W-1:0] fire;
            levels = poll.button_levels & BUTTON_MASK;
            prev   = last_levels;
            fire   = '0;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                if (levels[b]) begin
                    if (!prev[b]) begin
                        // fresh press fires at once and arms the first delay
                        fire[b]     = 1'b1;
                        deadline[b] = poll.now_ms + delay_ms;
                    end else if (poll.now_ms >= deadline[b]) begin
                        fire[b]     = 1'b1;
                        deadline[b] = poll.now_ms + rate_ms;
                    end
                end
            end
            last_levels              = levels;
            masks.pressed_mask       = levels;
            masks.just_pressed_mask  = levels & ~prev;
            masks.just_released_mask = prev & ~levels;
            masks.repeat_mask        = fire;
            firings += $countones(fire);
            expected_masks.push_back(masks);
        endfunction

        function void check_result(bas_pkg::t_out_item got);
            bas_pkg::t_out_item want;
            results_seen++;
            if (expected_masks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: %h %h %h %h",
                             got.pressed_mask, got.just_pressed_mask,
                             got.just_released_mask, got.repeat_mask);
                return;
            end
            want = expected_masks.pop_front();
            if (got.pressed_mask !== want.pressed_mask
                    || got.just_pressed_mask !== want.just_pressed_mask
                    || got.just_released_mask !== want.just_released_mask
                    || got.repeat_mask !== want.repeat_mask) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d held/pressed/released/repeat ",
                              "exp %h %h %h %h got %h %h %h %h"},
                             results_seen,
                             want.pressed_mask, want.just_pressed_mask,
                             want.just_released_mask, want.repeat_mask,
                             got.pressed_mask, got.just_pressed_mask,
                             got.just_released_mask, got.repeat_mask);
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    bas_pkg::t_in_item             i_in;
    logic                          o_out_valid;
    logic                          i_out_stall;
    bas_pkg::t_out_item            o_out;
    logic                          i_cfg_we;
    logic [bas_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bas_pkg::CFG_W-1:0]     i_cfg_data;

    autorepeat_scoreboard board;

    // idling knobs: quiet turns a side's gaps off for a whole phase
    bit tx_quiet;
    bit rx_quiet;
    bit long_hold_request;
    int hold_left;
    int rx_stall_left;
    int long_holds;
    int cycle_count;
    int polls_sent;
    int settings_used;

    // emulated millisecond clock and held buttons for the well-formed stream
    logic [bas_pkg::TIME_W-1:0]  clock_ms;
    logic [bas_pkg::FIELD_W-1:0] held_levels;

    button_autorepeat_scanner #(
        .NUM_BUTTONS (BUTTON_COUNT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: check accepted items at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_out);
    end

    // result side stall, driven at the falling edge
    always @(negedge i_clk) begin
        if (long_hold_request) begin
            hold_left = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
            long_holds++;
        end
        if (hold_left > 0) begin
            // long hold so the skid fills and the input side backs up
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            rx_stall_left = ($urandom_range(0, 99) < 75) ? 0 : pick_gap();
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_poll(input logic [bas_pkg::FIELD_W-1:0] levels,
                             input logic [bas_pkg::TIME_W-1:0] now);
        bas_pkg::t_in_item poll;
        int                gap;
        poll.button_levels = levels;
        poll.now_ms        = now;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= poll;
        do @(posedge i_clk); while (o_in_stall);
        board.note_poll(poll);
        polls_sent++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // drop valid and let every pending result drain before touching registers
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.expected_masks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [bas_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bas_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // next poll of the random stream: mostly a plausible time walk with
    // occasional toggles, some pure noise
    task automatic send_random_poll();
        logic [bas_pkg::FIELD_W-1:0] toggles;
        if ($urandom_range(0, 99) < 8) begin
            send_poll(bas_pkg::FIELD_W'($urandom), $urandom);
        end else begin
            if ($urandom_range(0, 99) < 80)
                clock_ms = clock_ms + $urandom_range(0, 8);
            else
                clock_ms = clock_ms + $urandom_range(9, 120);
            toggles = '0;
            for (int b = 0; b < bas_pkg::FIELD_W; b++)
                toggles[b] = ($urandom_range(0, 9) == 0);
            held_levels = held_levels ^ toggles;
            send_poll(held_levels, clock_ms);
        end
    endtask

    function automatic logic [bas_pkg::CFG_W-1:0] pick_setting();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return '0;
        if (roll < 14) return '1;
        if (roll < 20) return bas_pkg::CFG_W'($urandom);
        return bas_pkg::CFG_W'($urandom_range(0, 60));
    endfunction

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_in              = '0;
        i_out_stall       = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        tx_quiet          = 1'b0;
        rx_quiet          = 1'b0;
        long_hold_request = 1'b0;
        hold_left         = 0;
        rx_stall_left     = 0;
        long_holds        = 0;
        cycle_count       = 0;
        polls_sent        = 0;
        settings_used     = 0;
        clock_ms          = '0;
        held_levels       = '0;
        board = new();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset timing 500/100: press edges, exact deadline hit, release
        send_poll(12'h000, 32'd0);
        send_poll(12'hFFF, 32'd10);
        send_poll(12'hFFF, 32'd509);
        send_poll(12'hFFF, 32'd510);
        send_poll(12'h000, 32'd600);
        // press just below wrap: deadline wraps past zero and fires right away
        send_poll(12'hAAA, 32'hFFFF_FF00);
        send_poll(12'hAAA, 32'hFFFF_FFFF);
        send_poll(12'hFFF, 32'd0);
        send_poll(12'h555, 32'd5);
        wait_idle();

        // zero delay and rate: a held button fires every poll; spare slots ignored
        write_register(bas_pkg::CFG_IDX_DELAY, '0);
        write_register(bas_pkg::CFG_IDX_RATE, '0);
        write_register(CFG_IDX_SPARE_A, '1);
        write_register(CFG_IDX_SPARE_B, '1);
        send_poll(12'h001, 32'd1000);
        send_poll(12'h001, 32'd1000);
        send_poll(12'h801, 32'd1001);
        send_poll(12'h000, 32'd1002);
        wait_idle();

        // maximum delay and rate, deadline lands on the top and then wraps
        write_register(bas_pkg::CFG_IDX_DELAY, '1);
        write_register(bas_pkg::CFG_IDX_RATE, '1);
        send_poll(12'hFFF, 32'hFFFF_0000);
        send_poll(12'hFFF, 32'hFFFF_FFFE);
        send_poll(12'hFFF, 32'hFFFF_FFFF);
        send_poll(12'hFFF, 32'd0);
        send_poll(12'hFFF, 32'h0000_FFFE);
        send_poll(12'h000, 32'h0001_0000);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_register(bas_pkg::CFG_IDX_DELAY, pick_setting());
            write_register(bas_pkg::CFG_IDX_RATE, pick_setting());
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                               bas_pkg::CFG_W'($urandom));
            case ($urandom_range(0, 3))
                0: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                1: clock_ms = $urandom;
                default: ;
            endcase
            // one phase runs flat out on both sides, one backs up the input
            tx_quiet = (phase == 1) || (phase == 3);
            rx_quiet = (phase == 1);
            if (phase == 3)
                long_hold_request = 1'b1;
            repeat (POLLS_PER_PHASE) send_random_poll();
            wait_idle();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        if (board.expected_masks.size() != 0)
            $display("ERROR: %0d results never arrived", board.expected_masks.size());
        $display("run covered %0d polls, %0d results, %0d register writes",
                 polls_sent, board.results_seen, settings_used);
        $display("repeat firings predicted: %0d, long output holds: %0d, mismatches: %0d",
                 board.firings, long_holds, board.mismatches);
        if (board.mismatches == 0 && board.expected_masks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/bas_pkg.sv
rtl/core/bas_lane.sv
rtl/core/bas_merge.sv
rtl/core/button_autorepeat_scanner.sv
tb/tb_top.sv
